// ----- rtl/bodi_pkg.sv -----
`timescale 1ns / 1ps
package bodi_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;            // CORDIC vector and angle width
  localparam int MW = 56;            // multiplier operand width
  localparam int PW = 2 * MW;        // product width

  localparam logic [31:0] DEG_TO_TURN = 32'd3054198966;
  localparam logic [31:0] INV_TWO_PI  = 32'd683565276;
  localparam logic [30:0] CORDIC_UNIT = 31'd1073741824;
  localparam logic [30:0] CORDIC_INVK = 31'd652032875;

  typedef enum logic [1:0] {
    REG_MPC   = 2'd0,
    REG_RATIO = 2'd1,
    REG_INVWB = 2'd2
  } reg_idx_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/bodi_if.sv -----
`timescale 1ns / 1ps
interface bodi_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] count_delta;
  logic signed [15:0] steer_degrees;
  modport source (output valid, count_delta, steer_degrees, input ready);
  modport sink   (input valid, count_delta, steer_degrees, output ready);
endinterface

interface bodi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading_angle;
  modport source (output valid, pos_x, pos_y, heading_angle, input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, output ready);
endinterface

// ----- rtl/bodi_mul.sv -----
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle, product shifts right.
module bodi_mul import bodi_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [MW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  localparam int CNTW = $clog2(MW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [MW-1:0]   a_q, hi_q, lo_q;
  logic [MW:0]     sum;

  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        a_q    <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
      end else if (busy_q) begin
        hi_q  <= sum[MW:1];
        lo_q  <= {sum[0], lo_q[MW-1:1]};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(MW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ----- rtl/bodi_cordic.sv -----
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle, full-circle input.
module bodi_cordic import bodi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          angle_i,
  input  logic [30:0]          x0_i,
  output logic                 done_o,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam int SW = $clog2(CORDIC_STEPS);

  logic                 busy_q, done_q, flip_q;
  logic [SW-1:0]        i_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] xs, ys, at;
  logic                 flip;
  logic [31:0]          a0;

  assign flip = angle_i[31] ^ angle_i[30];   // angle + quarter turn crosses half
  assign a0   = flip ? (angle_i ^ 32'h8000_0000) : angle_i;
  assign xs   = x_q >>> i_q;
  assign ys   = y_q >>> i_q;
  assign at   = signed'({2'b00, atan_turn(5'(i_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        flip_q <= flip;
        x_q    <= signed'({3'b000, x0_i});
        y_q    <= '0;
        z_q    <= signed'({{(CW-32){a0[31]}}, a0});
      end else if (busy_q) begin
        if (!z_q[CW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        i_q <= i_q + 1'b1;
        if (i_q == SW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ----- rtl/bicycle_odometry_integrator_core.sv -----
`timescale 1ns / 1ps
// Each accepted word runs in turn through eight 56-step bit-serial multiplies, two
//   CORDIC runs and a 48-step restoring divide; the divide is skipped when the steer
//   tan saturates, and a stalled output adds its wait before the result word is raised.
// Input is taken only in idle, so a word is not accepted until the last one is done.
// A new input word is taken while the previous result still waits on the output.
// Reset (async, active low): pose clears to zero, registers load their defaults.
module bicycle_odometry_integrator_core import bodi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bodi_in_if.sink     in_w,
  bodi_out_if.source  out_w,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_M_DEG, ST_M_SIG, ST_M_DIST, ST_C_TAN, ST_DIV, ST_M_K1,
    ST_M_K2, ST_M_STEP, ST_C_HEAD, ST_M_DX, ST_M_DY, ST_UPD
  } state_e;

  // config registers
  logic [31:0] mpc_q;
  logic [15:0] ratio_q;
  logic [23:0] invwb_q;

  // pose
  logic signed [31:0] x_q, y_q;
  logic [31:0]        hd_q, hd_out_q;
  logic               out_valid_q;

  state_e state_q;
  logic   mul_start_q, cor_start_q;

  // per-word working values
  logic                 cnt_neg_q, steer_neg_q, tan_neg_q;
  logic [23:0]          cnt_mag_q;
  logic [16:0]          steer_mag_q;
  logic [32:0]          deg_mag_q;
  logic [31:0]          sig_q;
  logic [MW-1:0]        dmag_q;
  logic [30:0]          tan_q;
  logic [54:0]          t1_q, curv_q;
  logic signed [CW-1:0] hc_q, hs_q;
  logic [39:0]          dx_q;
  logic [39:0]          dy_q;

  // divider
  logic [34:0] rem_q;
  logic [47:0] num_q;
  logic [32:0] dvs_q;
  logic [5:0]  div_cnt_q;
  logic [34:0] shl;
  logic [35:0] trial;
  logic        ge;
  logic [47:0] num_nx;

  // shared units
  logic [MW-1:0]        mul_a, mul_b;
  logic                 mul_done;
  logic [PW-1:0]        prod;
  logic [31:0]          cor_angle;
  logic [30:0]          cor_x0;
  logic                 cor_done;
  logic signed [CW-1:0] cor_cos, cor_sin;

  logic [CW-1:0] sin_abs, hc_abs;
  logic [30:0]   step;
  logic [39:0]   dy;
  logic          neg_x, neg_y;
  logic signed [41:0] sum_x, sum_y;
  logic signed [31:0] x_new, y_new;

  bodi_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start_q), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(prod)
  );

  bodi_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start_q), .angle_i(cor_angle), .x0_i(cor_x0),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_M_DEG:  begin mul_a = MW'(ratio_q);   mul_b = MW'(steer_mag_q); end
      ST_M_SIG:  begin mul_a = MW'(deg_mag_q); mul_b = MW'(DEG_TO_TURN); end
      ST_M_DIST: begin mul_a = MW'(mpc_q);     mul_b = MW'(cnt_mag_q);   end
      ST_M_K1:   begin mul_a = MW'(tan_q);     mul_b = MW'(invwb_q);     end
      ST_M_K2:   begin mul_a = MW'(t1_q);      mul_b = MW'(INV_TWO_PI);  end
      ST_M_STEP: begin mul_a = MW'(curv_q);    mul_b = dmag_q;           end
      ST_M_DX:   begin mul_a = dmag_q;         mul_b = MW'(hc_abs);      end
      ST_M_DY:   begin mul_a = dmag_q;         mul_b = MW'(hc_abs);      end
      default:   ;
    endcase
    if (state_q == ST_M_DY) mul_b = MW'(hs_q[CW-1] ? -hs_q : hs_q);
  end

  assign cor_angle = (state_q == ST_C_HEAD) ? hd_q : sig_q;
  assign cor_x0    = (state_q == ST_C_HEAD) ? CORDIC_INVK : CORDIC_UNIT;

  assign sin_abs = cor_sin[CW-1] ? -cor_sin : cor_sin;
  assign hc_abs  = hc_q[CW-1] ? -hc_q : hc_q;

  // restoring divide step: one quotient bit a cycle
  assign shl    = {rem_q[33:0], num_q[47]};
  assign trial  = {1'b0, shl} - {3'b000, dvs_q};
  assign ge     = !trial[35];
  assign num_nx = {num_q[46:0], ge};

  // heading step, Q.32 turns, saturated just under half a turn
  assign step = (prod[111:63] != '0) ? 31'h7FFF_FFFF : prod[62:32];
  assign dy   = (prod[111:86] != '0) ? 40'hFF_FFFF_FFFF : prod[85:46];

  // x moves with cos, y against sin
  assign neg_x = cnt_neg_q ^ hc_q[CW-1];
  assign neg_y = !(cnt_neg_q ^ hs_q[CW-1]);
  assign sum_x = 42'(x_q) + (neg_x ? -42'(dx_q) : 42'(dx_q));
  assign sum_y = 42'(y_q) + (neg_y ? -42'(dy_q) : 42'(dy_q));

  always_comb begin
    if (sum_x[41:31] == '0 || sum_x[41:31] == '1) x_new = sum_x[31:0];
    else x_new = sum_x[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (sum_y[41:31] == '0 || sum_y[41:31] == '1) y_new = sum_y[31:0];
    else y_new = sum_y[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_start_q <= 1'b0;
      cor_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      hd_q        <= '0;
      hd_out_q    <= '0;
      div_cnt_q   <= '0;
    end else begin
      mul_start_q <= 1'b0;
      cor_start_q <= 1'b0;
      if (out_valid_q && out_w.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_w.valid) begin
            cnt_neg_q   <= in_w.count_delta[23];
            cnt_mag_q   <= in_w.count_delta[23] ? 24'(-in_w.count_delta)
                                                : in_w.count_delta;
            steer_neg_q <= in_w.steer_degrees[15];
            steer_mag_q <= in_w.steer_degrees[15] ? 17'(-18'(in_w.steer_degrees))
                                                  : 17'(in_w.steer_degrees);
            mul_start_q <= 1'b1;
            state_q     <= ST_M_DEG;
          end
        end
        ST_M_DEG: if (mul_done) begin
          deg_mag_q   <= prod[32:0];
          mul_start_q <= 1'b1;
          state_q     <= ST_M_SIG;
        end
        ST_M_SIG: if (mul_done) begin
          sig_q       <= steer_neg_q ? -prod[63:32] : prod[63:32];
          mul_start_q <= 1'b1;
          state_q     <= ST_M_DIST;
        end
        ST_M_DIST: if (mul_done) begin
          dmag_q      <= prod[MW-1:0];
          cor_start_q <= 1'b1;
          state_q     <= ST_C_TAN;
        end
        ST_C_TAN: if (cor_done) begin
          tan_neg_q <= cor_sin[CW-1];
          if (cor_cos[CW-1] || cor_cos == '0) begin
            // wheel at or past a right angle: tan pinned at full scale
            tan_q       <= 31'h7FFF_FFFF;
            mul_start_q <= 1'b1;
            state_q     <= ST_M_K1;
          end else begin
            rem_q     <= '0;
            num_q     <= {sin_abs[31:0], 16'h0000};
            dvs_q     <= cor_cos[32:0];
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q     <= ge ? trial[34:0] : shl;
          num_q     <= num_nx;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == 6'd47) begin
            tan_q       <= (num_nx[47:31] != '0) ? 31'h7FFF_FFFF : num_nx[30:0];
            mul_start_q <= 1'b1;
            state_q     <= ST_M_K1;
          end
        end
        ST_M_K1: if (mul_done) begin
          t1_q        <= prod[54:0];
          mul_start_q <= 1'b1;
          state_q     <= ST_M_K2;
        end
        ST_M_K2: if (mul_done) begin
          curv_q      <= prod[86:32];
          mul_start_q <= 1'b1;
          state_q     <= ST_M_STEP;
        end
        ST_M_STEP: if (mul_done) begin
          hd_q        <= (cnt_neg_q != tan_neg_q) ? hd_q - 32'(step) : hd_q + 32'(step);
          cor_start_q <= 1'b1;
          state_q     <= ST_C_HEAD;
        end
        ST_C_HEAD: if (cor_done) begin
          hc_q        <= cor_cos;
          hs_q        <= cor_sin;
          mul_start_q <= 1'b1;
          state_q     <= ST_M_DX;
        end
        ST_M_DX: if (mul_done) begin
          dx_q        <= dy;
          mul_start_q <= 1'b1;
          state_q     <= ST_M_DY;
        end
        ST_M_DY: if (mul_done) begin
          dy_q    <= dy;
          state_q <= ST_UPD;
        end
        ST_UPD: if (!out_valid_q || out_w.ready) begin
          x_q         <= x_new;
          y_q         <= y_new;
          hd_out_q    <= hd_q;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpc_q   <= 32'd130150;
      ratio_q <= 16'd7209;
      invwb_q <= 24'd94975;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_MPC:   mpc_q   <= pwdata;
        REG_RATIO: ratio_q <= pwdata[15:0];
        REG_INVWB: invwb_q <= pwdata[23:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_MPC:   prdata = mpc_q;
      REG_RATIO: prdata = {16'h0000, ratio_q};
      REG_INVWB: prdata = {8'h00, invwb_q};
      default:   prdata = '0;
    endcase
  end

  assign pready              = 1'b1;
  assign in_w.ready          = (state_q == ST_IDLE);
  assign out_w.valid         = out_valid_q;
  assign out_w.pos_x         = x_q;
  assign out_w.pos_y         = y_q;
  assign out_w.heading_angle = hd_out_q;

  // a result word only ever comes from the pose update
  a_out_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result word raised outside pose update");

  // heading moves only as the step multiply retires
  a_hd_only_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hd_q) |-> $past(state_q == ST_M_STEP && mul_done))
    else $error("heading changed outside step update");

  // CORDIC finishes only while the sequencer waits on it
  a_cor_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == ST_C_TAN || state_q == ST_C_HEAD))
    else $error("CORDIC done in wrong state");

endmodule
